// File: rtl/bal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

	localparam int MODE_W  = 3;
	localparam int DATA_W  = 64;
	localparam int POS_W   = 8;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;
	localparam int ITER_W  = $clog2(POS_W);

	localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROTATE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DISPLAY = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BADIDX = 2'd3;

	// Reversal ranges: a left rotate by k is rev[0,k-1], rev[k,n-1], rev[0,n-1]
	localparam logic [1:0] PH_HEAD = 2'd0;
	localparam logic [1:0] PH_TAIL = 2'd1;
	localparam logic [1:0] PH_ALL  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SH_STEP,
		ST_SH_WR,
		ST_INS_WR,
		ST_MOD,
		ST_ROT_SET,
		ST_SW_SET,
		ST_SW_CHK,
		ST_SW_RD_LO,
		ST_SW_RD_HI,
		ST_SW_WR_LO,
		ST_SW_WR_HI,
		ST_DSP_RD,
		ST_DSP_OUT,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

// File: rtl/bounded_array_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Beat contents
// in       sink       in_valid/in_stall   mode, value, position, to_left
// out      source     out_valid/out_stall element, status, count, last
//
// One command at a time; in_stall is low only while the sequencer is idle.
// Append writes at the end; Insert moves the elements from the position up a slot,
// then writes. Reverse swaps pairs from both ends inward. Rotate reduces the amount
// modulo the count, then runs three reversal passes unless the result is zero.
// Display sends the elements in order; the memory has one read and one write port.
// A stall on out holds the sequencer; reset empties the list, with no clearing pass.
module bounded_array_list_engine #(
	parameter int CAPACITY = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [bal_pkg::MODE_W-1:0]        mode,
	input  wire logic signed [bal_pkg::DATA_W-1:0] value,
	input  wire logic [bal_pkg::POS_W-1:0]         position,
	input  wire logic                              to_left,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [bal_pkg::DATA_W-1:0]      element,
	output logic [bal_pkg::STAT_W-1:0]             status,
	output logic [bal_pkg::COUNT_W-1:0]            count,
	output logic                                   last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > bal_pkg::POS_W) ? CW : bal_pkg::POS_W;
	localparam int RW = CW + 1;

	bal_pkg::state_t state_q, state_d;

	logic [CW-1:0]                  fill_q;
	logic                           out_valid_q;
	logic [bal_pkg::DATA_W-1:0]     mem_q [CAPACITY];
	logic [bal_pkg::DATA_W-1:0]     rd_q;
	logic [bal_pkg::DATA_W-1:0]     tmp_q;
	logic [bal_pkg::DATA_W-1:0]     value_q;
	logic                           to_left_q;
	logic [bal_pkg::POS_W-1:0]      pos_q;
	logic [AW-1:0]                  cur_q, idx_q, kl_q, lo_q, hi_q, dsp_q;
	logic [RW-1:0]                  rem_q;
	logic [bal_pkg::ITER_W-1:0]     iter_q;
	logic [1:0]                     phase_q;
	logic [bal_pkg::STAT_W-1:0]     st_q;
	logic [bal_pkg::DATA_W-1:0]     element_q;
	logic [bal_pkg::STAT_W-1:0]     status_q;
	logic [bal_pkg::COUNT_W-1:0]    count_q;
	logic                           last_q;

	logic                           in_acc, out_free, full, empty, bad_idx;
	logic [bal_pkg::STAT_W-1:0]     acc_status;
	logic [AW-1:0]                  last_idx;
	logic [RW-1:0]                  rem_sh;
	logic                           rd_en, wr_en, out_load, out_last;
	logic [AW-1:0]                  rd_addr, wr_addr;
	logic [bal_pkg::DATA_W-1:0]     wr_data, out_elem;
	logic [bal_pkg::STAT_W-1:0]     out_stat;

	assign in_stall  = (state_q != bal_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (fill_q == CW'(CAPACITY));
	assign empty     = (fill_q == '0);
	assign bad_idx   = (XW'(position) > XW'(fill_q));
	assign last_idx  = AW'(fill_q - CW'(1));
	assign rem_sh    = {rem_q[CW-1:0], pos_q[bal_pkg::POS_W-1]};

	assign out_valid = out_valid_q;
	assign element   = element_q;
	assign status    = status_q;
	assign count     = count_q;
	assign last      = last_q;

	always_comb begin
		case (mode)
			bal_pkg::MODE_APPEND:  acc_status = full ? bal_pkg::STAT_FULL : bal_pkg::STAT_OK;
			bal_pkg::MODE_INSERT: begin
				if (full)
					acc_status = bal_pkg::STAT_FULL;
				else if (bad_idx)
					acc_status = bal_pkg::STAT_BADIDX;
				else
					acc_status = bal_pkg::STAT_OK;
			end
			bal_pkg::MODE_ROTATE, bal_pkg::MODE_REVERSE, bal_pkg::MODE_DISPLAY:
				acc_status = empty ? bal_pkg::STAT_EMPTY : bal_pkg::STAT_OK;
			default:               acc_status = bal_pkg::STAT_OK;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bal_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (acc_status != bal_pkg::STAT_OK)
						state_d = bal_pkg::ST_RESP;
					else begin
						case (mode)
							bal_pkg::MODE_APPEND,
							bal_pkg::MODE_INSERT:  state_d = bal_pkg::ST_SH_STEP;
							bal_pkg::MODE_ROTATE:  state_d = bal_pkg::ST_MOD;
							bal_pkg::MODE_REVERSE: state_d = bal_pkg::ST_SW_SET;
							bal_pkg::MODE_DISPLAY: state_d = bal_pkg::ST_DSP_RD;
							default:               state_d = bal_pkg::ST_RESP;
						endcase
					end
				end
			end
			bal_pkg::ST_SH_STEP:
				state_d = (cur_q == idx_q) ? bal_pkg::ST_INS_WR : bal_pkg::ST_SH_WR;
			bal_pkg::ST_SH_WR:   state_d = bal_pkg::ST_SH_STEP;
			bal_pkg::ST_INS_WR:  state_d = bal_pkg::ST_RESP;
			bal_pkg::ST_MOD: begin
				if (iter_q == bal_pkg::ITER_W'(bal_pkg::POS_W - 1))
					state_d = bal_pkg::ST_ROT_SET;
			end
			bal_pkg::ST_ROT_SET:
				state_d = (rem_q == '0) ? bal_pkg::ST_RESP : bal_pkg::ST_SW_SET;
			bal_pkg::ST_SW_SET:  state_d = bal_pkg::ST_SW_CHK;
			bal_pkg::ST_SW_CHK: begin
				if (lo_q < hi_q)
					state_d = bal_pkg::ST_SW_RD_LO;
				else if (phase_q == bal_pkg::PH_ALL)
					state_d = bal_pkg::ST_RESP;
				else
					state_d = bal_pkg::ST_SW_SET;
			end
			bal_pkg::ST_SW_RD_LO: state_d = bal_pkg::ST_SW_RD_HI;
			bal_pkg::ST_SW_RD_HI: state_d = bal_pkg::ST_SW_WR_LO;
			bal_pkg::ST_SW_WR_LO: state_d = bal_pkg::ST_SW_WR_HI;
			bal_pkg::ST_SW_WR_HI: state_d = bal_pkg::ST_SW_CHK;
			bal_pkg::ST_DSP_RD:   state_d = bal_pkg::ST_DSP_OUT;
			bal_pkg::ST_DSP_OUT: begin
				if (out_free)
					state_d = (dsp_q == last_idx) ? bal_pkg::ST_IDLE : bal_pkg::ST_DSP_RD;
			end
			bal_pkg::ST_RESP: begin
				if (out_free)
					state_d = bal_pkg::ST_IDLE;
			end
			default:              state_d = bal_pkg::ST_IDLE;
		endcase
	end

	// Memory port and result strobes
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = rd_q;
		out_load = 1'b0;
		out_elem = '0;
		out_stat = st_q;
		out_last = 1'b1;
		case (state_q)
			bal_pkg::ST_SH_STEP: begin
				rd_en   = (cur_q != idx_q);
				rd_addr = cur_q - AW'(1);
			end
			bal_pkg::ST_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = cur_q;
			end
			bal_pkg::ST_INS_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = value_q;
			end
			bal_pkg::ST_SW_RD_LO: begin
				rd_en   = 1'b1;
				rd_addr = lo_q;
			end
			bal_pkg::ST_SW_RD_HI: begin
				rd_en   = 1'b1;
				rd_addr = hi_q;
			end
			bal_pkg::ST_SW_WR_LO: begin
				wr_en   = 1'b1;
				wr_addr = lo_q;
			end
			bal_pkg::ST_SW_WR_HI: begin
				wr_en   = 1'b1;
				wr_addr = hi_q;
				wr_data = tmp_q;
			end
			bal_pkg::ST_DSP_RD: begin
				rd_en   = 1'b1;
				rd_addr = dsp_q;
			end
			bal_pkg::ST_DSP_OUT: begin
				out_load = out_free;
				out_elem = rd_q;
				out_stat = bal_pkg::STAT_OK;
				out_last = (dsp_q == last_idx);
			end
			bal_pkg::ST_RESP: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bal_pkg::ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bal_pkg::ST_INS_WR)
				fill_q <= fill_q + CW'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			element_q <= out_elem;
			status_q  <= out_stat;
			count_q   <= bal_pkg::COUNT_W'(fill_q);
			last_q    <= out_last;
		end
		case (state_q)
			bal_pkg::ST_IDLE: begin
				if (in_acc) begin
					value_q   <= value;
					to_left_q <= to_left;
					pos_q     <= position;
					st_q      <= acc_status;
					cur_q     <= AW'(fill_q);
					idx_q     <= (mode == bal_pkg::MODE_APPEND) ? AW'(fill_q) : AW'(position);
					rem_q     <= '0;
					iter_q    <= '0;
					phase_q   <= bal_pkg::PH_ALL;
					dsp_q     <= '0;
				end
			end
			bal_pkg::ST_SH_WR: cur_q <= cur_q - AW'(1);
			// Restoring remainder, one position bit per cycle
			bal_pkg::ST_MOD: begin
				rem_q  <= (rem_sh >= RW'(fill_q)) ? rem_sh - RW'(fill_q) : rem_sh;
				pos_q  <= pos_q << 1;
				iter_q <= iter_q + bal_pkg::ITER_W'(1);
			end
			// Right rotate by k is a left rotate by n - k
			bal_pkg::ST_ROT_SET: begin
				kl_q    <= to_left_q ? AW'(rem_q) : AW'(fill_q - rem_q[CW-1:0]);
				phase_q <= bal_pkg::PH_HEAD;
			end
			bal_pkg::ST_SW_SET: begin
				case (phase_q)
					bal_pkg::PH_HEAD: begin
						lo_q <= '0;
						hi_q <= kl_q - AW'(1);
					end
					bal_pkg::PH_TAIL: begin
						lo_q <= kl_q;
						hi_q <= last_idx;
					end
					default: begin
						lo_q <= '0;
						hi_q <= last_idx;
					end
				endcase
			end
			bal_pkg::ST_SW_CHK: begin
				if (!(lo_q < hi_q) && phase_q != bal_pkg::PH_ALL)
					phase_q <= phase_q + 2'd1;
			end
			bal_pkg::ST_SW_RD_HI: tmp_q <= rd_q;
			bal_pkg::ST_SW_WR_HI: begin
				lo_q <= lo_q + AW'(1);
				hi_q <= hi_q - AW'(1);
			end
			bal_pkg::ST_DSP_OUT: begin
				if (out_free)
					dsp_q <= dsp_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/bal_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module bal_chk #(
	parameter int CAPACITY = 16
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic [bal_pkg::MODE_W-1:0]        mode,
	input wire logic signed [bal_pkg::DATA_W-1:0] value,
	input wire logic [bal_pkg::POS_W-1:0]         position,
	input wire logic                              to_left,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [bal_pkg::DATA_W-1:0] element,
	input wire logic [bal_pkg::STAT_W-1:0]        status,
	input wire logic [bal_pkg::COUNT_W-1:0]       count,
	input wire logic                              last
);

	// Every accepted command makes the block busy in the following cycle
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on back-to-back cycles");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(element) && $stable(status)
			&& $stable(count) && $stable(last))
		else $error("stalled result beat changed");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bal_pkg::STAT_EMPTY |-> count == '0 && last)
		else $error("empty status with elements held");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bal_pkg::STAT_FULL |->
			count == bal_pkg::COUNT_W'(CAPACITY) && last && element == '0)
		else $error("full status with list not at capacity");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bal_pkg::STAT_OK |-> element == '0)
		else $error("error result carries an element");

endmodule

bind bounded_array_list_engine bal_chk #(.CAPACITY(CAPACITY)) u_bal_chk (.*);

`default_nettype wire

// File: tb/tb_bounded_array_list_engine.sv
`timescale 1ns / 1ps

module tb_bounded_array_list_engine;

	localparam int LIST_CAP = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 40;
	localparam logic [bal_pkg::MODE_W-1:0] MODE_UNUSED_FIRST = bal_pkg::MODE_DISPLAY + 1'b1;
	localparam logic [bal_pkg::MODE_W-1:0] MODE_UNUSED_LAST = '1;
	localparam logic signed [bal_pkg::DATA_W-1:0] ELEM_MAX = {1'b0, {(bal_pkg::DATA_W-1){1'b1}}};
	localparam logic signed [bal_pkg::DATA_W-1:0] ELEM_MIN = {1'b1, {(bal_pkg::DATA_W-1){1'b0}}};

	typedef struct packed {
		logic signed [bal_pkg::DATA_W-1:0] element;
		logic [bal_pkg::STAT_W-1:0] status;
		logic [bal_pkg::COUNT_W-1:0] count;
		logic last;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [bal_pkg::MODE_W-1:0] mode = bal_pkg::MODE_APPEND;
	logic signed [bal_pkg::DATA_W-1:0] value = '0;
	logic [bal_pkg::POS_W-1:0] position = '0;
	logic to_left = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [bal_pkg::DATA_W-1:0] element;
	logic [bal_pkg::STAT_W-1:0] status;
	logic [bal_pkg::COUNT_W-1:0] count;
	logic last;

	// list contents as the block should hold them
	logic signed [bal_pkg::DATA_W-1:0] list_mem [LIST_CAP];
	int list_len = 0;
	list_result_t pending_results [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int results_checked = 0;
	int mode_hits [8];
	int quiet_cycles = 0;

	bounded_array_list_engine #(.CAPACITY(LIST_CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.value(value),
		.position(position),
		.to_left(to_left),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.element(element),
		.status(status),
		.count(count),
		.last(last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void apply_list_command(input logic [bal_pkg::MODE_W-1:0] cmd,
			input logic signed [bal_pkg::DATA_W-1:0] item,
			input logic [bal_pkg::POS_W-1:0] pos, input logic left);
		list_result_t res;
		logic signed [bal_pkg::DATA_W-1:0] moved [LIST_CAP];
		logic signed [bal_pkg::DATA_W-1:0] held;
		int slot;
		int k;
		res = '{element: '0, status: bal_pkg::STAT_OK, count: '0, last: 1'b1};
		mode_hits[cmd]++;
		case (cmd)
			bal_pkg::MODE_APPEND, bal_pkg::MODE_INSERT: begin
				// full takes priority over a bad index
				if (list_len >= LIST_CAP)
					res.status = bal_pkg::STAT_FULL;
				else if (cmd == bal_pkg::MODE_INSERT && pos > list_len)
					res.status = bal_pkg::STAT_BADIDX;
				else begin
					slot = (cmd == bal_pkg::MODE_APPEND) ? list_len : int'(pos);
					for (int i = list_len; i > slot; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[slot] = item;
					list_len++;
				end
			end
			bal_pkg::MODE_ROTATE: begin
				if (list_len == 0)
					res.status = bal_pkg::STAT_EMPTY;
				else begin
					k = int'(pos) % list_len;
					for (int i = 0; i < list_len; i++)
						moved[i] = left ? list_mem[(i + k) % list_len]
							: list_mem[(i + list_len - k) % list_len];
					for (int i = 0; i < list_len; i++)
						list_mem[i] = moved[i];
				end
			end
			bal_pkg::MODE_REVERSE: begin
				if (list_len == 0)
					res.status = bal_pkg::STAT_EMPTY;
				else begin
					for (int i = 0; i < list_len / 2; i++) begin
						held = list_mem[i];
						list_mem[i] = list_mem[list_len-1-i];
						list_mem[list_len-1-i] = held;
					end
				end
			end
			bal_pkg::MODE_DISPLAY: begin
				if (list_len == 0)
					res.status = bal_pkg::STAT_EMPTY;
				else begin
					for (int i = 0; i < list_len; i++) begin
						res.element = list_mem[i];
						res.count = bal_pkg::COUNT_W'(list_len);
						res.last = (i == list_len - 1);
						pending_results.push_back(res);
					end
					return;
				end
			end
			default: ;
		endcase
		res.count = bal_pkg::COUNT_W'(list_len);
		pending_results.push_back(res);
	endfunction

	task automatic check_field(input string field, input logic [bal_pkg::DATA_W-1:0] want_v,
			input logic [bal_pkg::DATA_W-1:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin : score_beats
		list_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				apply_list_command(mode, value, position, to_left);
			if (out_valid && !out_stall) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat, expected none, %s %0h %0d %0d %0b",
						$time, "got element/status/count/last", element, status, count,
						last);
				end else begin
					want = pending_results.pop_front();
					check_field("element", want.element, element);
					check_field("status", bal_pkg::DATA_W'(want.status),
						bal_pkg::DATA_W'(status));
					check_field("count", bal_pkg::DATA_W'(want.count),
						bal_pkg::DATA_W'(count));
					check_field("last", bal_pkg::DATA_W'(want.last), bal_pkg::DATA_W'(last));
				end
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, pending_results.size());
			$display("tb_bounded_array_list_engine NOT OK");
			$finish;
		end
	end

	task automatic send_command(input logic [bal_pkg::MODE_W-1:0] cmd,
			input logic signed [bal_pkg::DATA_W-1:0] item,
			input logic [bal_pkg::POS_W-1:0] pos, input logic left);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		mode <= cmd;
		value <= item;
		position <= pos;
		to_left <= left;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// drop valid and hold off until every result is back
	task automatic wait_for_results;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_list;
		send_command(bal_pkg::MODE_DISPLAY, '0, '0, 1'b0);
		send_command(bal_pkg::MODE_ROTATE, '0, 8'd5, 1'b1);
		send_command(bal_pkg::MODE_REVERSE, '0, '0, 1'b0);
		send_command(bal_pkg::MODE_INSERT, ELEM_MAX, 8'd255, 1'b0);
		send_command(MODE_UNUSED_LAST, ELEM_MIN, 8'd255, 1'b1);
		wait_for_results();
	endtask

	task automatic test_small_edits;
		send_command(bal_pkg::MODE_APPEND, ELEM_MAX, '0, 1'b0);
		send_command(bal_pkg::MODE_APPEND, ELEM_MIN, '0, 1'b0);
		send_command(bal_pkg::MODE_INSERT, -64'sd1, 8'd0, 1'b0);
		send_command(bal_pkg::MODE_INSERT, 64'sh5555_5555_5555_5555, 8'd3, 1'b0);
		send_command(bal_pkg::MODE_INSERT, 64'shAAAA_AAAA_AAAA_AAAA, 8'd2, 1'b1);
		send_command(bal_pkg::MODE_INSERT, 64'sd7, 8'd7, 1'b0);
		wait_for_results();
	endtask

	task automatic test_rotate_reverse;
		send_command(bal_pkg::MODE_ROTATE, '0, 8'd0, 1'b1);
		send_command(bal_pkg::MODE_ROTATE, '0, bal_pkg::POS_W'(list_len), 1'b0);
		send_command(bal_pkg::MODE_ROTATE, '0, 8'd1, 1'b1);
		send_command(bal_pkg::MODE_ROTATE, '0, 8'd254, 1'b0);
		send_command(bal_pkg::MODE_REVERSE, '0, '0, 1'b0);
		send_command(bal_pkg::MODE_DISPLAY, '0, '0, 1'b0);
		wait_for_results();
	endtask

	task automatic test_random_traffic(input int items, input int sender_idle,
			input int receiver_stall);
		int pick;
		logic [bal_pkg::MODE_W-1:0] cmd;
		logic signed [bal_pkg::DATA_W-1:0] item;
		logic [bal_pkg::POS_W-1:0] pos;
		logic left;
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		repeat (items) begin
			pick = $urandom_range(99);
			item = {$urandom, $urandom};
			pos = bal_pkg::POS_W'($urandom_range(255));
			left = 1'($urandom_range(1));
			if (pick < 8)
				cmd = bal_pkg::MODE_APPEND;
			else if (pick < 20) begin
				cmd = bal_pkg::MODE_INSERT;
				if (pick < 15)
					pos = bal_pkg::POS_W'($urandom_range(list_len));
			end else if (pick < 55) begin
				cmd = bal_pkg::MODE_ROTATE;
				if (pick < 45)
					pos = bal_pkg::POS_W'($urandom_range(2 * LIST_CAP));
			end else if (pick < 70)
				cmd = bal_pkg::MODE_REVERSE;
			else if (pick < 94)
				cmd = bal_pkg::MODE_DISPLAY;
			else
				cmd = bal_pkg::MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
			send_command(cmd, item, pos, left);
		end
		wait_for_results();
	endtask

	task automatic test_full_list;
		while (list_len < LIST_CAP) begin
			send_command(bal_pkg::MODE_APPEND, {$urandom, $urandom}, '0, 1'b0);
			wait_for_results();
		end
		send_command(bal_pkg::MODE_APPEND, ELEM_MAX, '0, 1'b0);
		send_command(bal_pkg::MODE_INSERT, ELEM_MIN, 8'd0, 1'b0);
		send_command(bal_pkg::MODE_INSERT, ELEM_MIN, 8'd255, 1'b1);
		send_command(bal_pkg::MODE_ROTATE, '0, 8'd255, 1'b1);
		send_command(bal_pkg::MODE_DISPLAY, '0, '0, 1'b0);
		wait_for_results();
	endtask

	initial begin
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_small_edits();
		test_rotate_reverse();
		test_random_traffic(110, 0, 0);
		test_random_traffic(110, 54, 0);
		test_random_traffic(110, 0, 54);
		test_random_traffic(110, 35, 35);
		test_full_list();

		repeat (TAIL_CYCLES)
			@(posedge clk);
		$display("Ran %0d append, %0d insert, %0d rotate, %0d reverse, %0d display,",
			mode_hits[bal_pkg::MODE_APPEND], mode_hits[bal_pkg::MODE_INSERT],
			mode_hits[bal_pkg::MODE_ROTATE], mode_hits[bal_pkg::MODE_REVERSE],
			mode_hits[bal_pkg::MODE_DISPLAY]);
		$display("%0d spare-code commands under four idle/stall mixes; %0d result beats checked",
			mode_hits[5] + mode_hits[6] + mode_hits[7], results_checked);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb_bounded_array_list_engine OK");
		else
			$display("tb_bounded_array_list_engine NOT OK");
		$finish;
	end

endmodule

// File: bounded_array_list_engine.f
rtl/bal_pkg.sv
rtl/bounded_array_list_engine.sv
rtl/bal_chk.sv
tb/tb_bounded_array_list_engine.sv
